// ----- design/hysteresis_window_comparator_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the hysteresis window comparator
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef HYSTERESIS_WINDOW_COMPARATOR_MACROS_SVH
`define HYSTERESIS_WINDOW_COMPARATOR_MACROS_SVH

`ifndef SYNTHESIS

// antecedent holds -> consequent holds in the same cycle
`define HWC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hwc assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define HWC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hwc assertion failed");

`else

`define HWC_ASSERT_IMPL(lbl, ante, cons)
`define HWC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- design/hwc_pkg.sv -----
// ---------------------------------------------------------------------------
// hwc_pkg
// Shared types, constants and helpers of the hysteresis window comparator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hwc_pkg;

  localparam int DATA_W    = 32;
  localparam int BAND_W    = 31;
  localparam int IVL_W     = 16;
  localparam int CODE_W    = 3;
  localparam int CFG_IDX_W = 3;
  // sign-extended differences of three 32-bit terms need 34 bits
  localparam int CMP_STEPS = DATA_W + 2;
  localparam int DIV_STEPS = DATA_W;
  localparam int CNT_W     = $clog2(CMP_STEPS);

  typedef enum logic [CODE_W-1:0] {
    LV_NONE = 3'd0,
    LV_LOW  = 3'd1,
    LV_HIGH = 3'd2,
    LV_IN   = 3'd3,
    LV_OUT  = 3'd4
  } level_t;

  localparam level_t INITIAL_STATE_DEF = LV_NONE;

  typedef enum logic [1:0] {
    EM_CHANGE   = 2'd0,
    EM_ALWAYS   = 2'd1,
    EM_INTERVAL = 2'd2
  } emit_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COMPARE_MODE = 3'd0,
    REG_EMIT_MODE    = 3'd1,
    REG_INTERVAL     = 3'd2,
    REG_LOWER_LIMIT  = 3'd3,
    REG_UPPER_LIMIT  = 3'd4,
    REG_HYST_BAND    = 3'd5,
    REG_LOW_OUTPUT   = 3'd6,
    REG_HIGH_OUTPUT  = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_EVAL = 2'd2
  } fsm_t;

  typedef struct packed {
    logic load;
    logic cmp_step;
    logic div_step;
  } step_ctrl_t;

  typedef struct packed {
    logic ge_hi;  // sample >= upper + band
    logic le_lo;  // sample <= lower - band
    logic lt_lo;  // sample <  lower
    logic gt_hi;  // sample >  upper
  } cmp_flags_t;

  // one-bit full adder: {carry, sum}
  function automatic logic [1:0] fa(input logic a, input logic b, input logic c);
    fa = {(a & b) | (a & c) | (b & c), a ^ b ^ c};
  endfunction

endpackage

// ----- design/hwc_in_if.sv -----
// ---------------------------------------------------------------------------
// hwc_in_if
// Sample channel: valid/ready handshake with the timestamped sample.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hwc_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [hwc_pkg::DATA_W-1:0] sample;
  logic                              sample_valid;
  logic        [hwc_pkg::DATA_W-1:0] time_sec;

  modport source (output valid, sample, sample_valid, time_sec, input ready);
  modport sink   (input valid, sample, sample_valid, time_sec, output ready);
endinterface

// ----- design/hwc_out_if.sv -----
// ---------------------------------------------------------------------------
// hwc_out_if
// Result channel: valid/ready handshake with the selected value and level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hwc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [hwc_pkg::DATA_W-1:0] out_value;
  logic        [hwc_pkg::CODE_W-1:0] state_code;

  modport source (output valid, out_value, state_code, input ready);
  modport sink   (input valid, out_value, state_code, output ready);
endinterface

// ----- design/hysteresis_window_comparator.sv -----
// ---------------------------------------------------------------------------
// hysteresis_window_comparator
// Schmitt trigger / window comparator on timestamped Q16.16 samples.
// ---------------------------------------------------------------------------
// A valid sample is captured at the edge that accepts it, and its result is
// then formed in 34 bit-serial steps, in which the comparator forms its
// 34-bit sign-extended differences (the 32-step remainder divider for the
// interval test runs alongside), and one step to update the level and load
// the output register. The sequencer then returns to idle, and only there
// is a valid sample accepted, even while the last result still waits to be
// taken; the evaluation step holds only if a new result meets a full output
// register. A sample flagged invalid is taken and causes nothing. Configuration is
// to be written through the cfg_ port with the block idle; the block itself does
// not enforce this. There is no clearing pass after reset.
`timescale 1ns / 1ps

`include "hysteresis_window_comparator_macros.svh"

module hysteresis_window_comparator #(
  parameter hwc_pkg::level_t INITIAL_STATE = hwc_pkg::INITIAL_STATE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  hwc_in_if.sink                        in_ch,
  hwc_out_if.source                     out_ch,
  input  logic                          cfg_wr_en,
  input  logic [hwc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hwc_pkg::DATA_W-1:0]    cfg_data
);
  import hwc_pkg::*;

  // configuration
  logic                     compare_mode_r;
  emit_t                    emit_mode_r;
  logic [IVL_W-1:0]         interval_r;
  logic signed [DATA_W-1:0] lower_r, upper_r;
  logic [BAND_W-1:0]        band_r;
  logic signed [DATA_W-1:0] low_out_r, high_out_r;

  fsm_t             state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  level_t           level_r, level_nxt;
  logic             out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  level_t           out_code_r;

  step_ctrl_t ctrl;
  cmp_flags_t flags;
  logic       rem_zero;
  logic       accept, last_step, slot_free;
  logic       changed, fire, emit, commit;

  assign accept    = in_ch.valid && in_ch.ready;
  assign last_step = (cnt_r == CNT_W'(CMP_STEPS - 1));
  assign slot_free = !out_valid_r || out_ch.ready;

  hwc_serial_cmp u_cmp (
    .clk    (clk),
    .ctrl   (ctrl),
    .sample (in_ch.sample),
    .lower  (lower_r),
    .upper  (upper_r),
    .band   (band_r),
    .flags  (flags)
  );

  hwc_serial_mod u_mod (
    .clk      (clk),
    .ctrl     (ctrl),
    .dividend (in_ch.time_sec),
    .divisor  (interval_r),
    .rem_zero (rem_zero)
  );

  // level decision
  always_comb begin
    level_nxt = level_r;
    if (!compare_mode_r) begin
      if (flags.ge_hi) begin
        level_nxt = LV_HIGH;
      end
      // low wins when both thresholds are met
      if (flags.le_lo) begin
        level_nxt = LV_LOW;
      end
    end else begin
      level_nxt = (flags.lt_lo || flags.gt_hi) ? LV_OUT : LV_IN;
    end
    changed = (level_nxt != level_r);
    case (emit_mode_r)
      EM_ALWAYS:   fire = 1'b1;
      EM_INTERVAL: fire = (interval_r != '0) && rem_zero;
      default:     fire = 1'b0;
    endcase
    emit = (changed || fire) && (level_nxt != LV_NONE);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_ch.sample_valid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_step) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready   = (state_r == ST_IDLE);
    ctrl.load     = (state_r == ST_IDLE) && accept && in_ch.sample_valid;
    ctrl.cmp_step = (state_r == ST_RUN);
    ctrl.div_step = (state_r == ST_RUN) && (cnt_r < CNT_W'(DIV_STEPS));
    // hold the evaluation while a result would meet a full output register
    commit        = (state_r == ST_EVAL) && (!emit || slot_free);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      level_r <= INITIAL_STATE;
    end else begin
      state_r <= state_nxt;
      if (ctrl.load) begin
        cnt_r <= '0;
      end else if (ctrl.cmp_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (commit) begin
        level_r <= level_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && emit) begin
      out_code_r  <= level_nxt;
      out_value_r <= (level_nxt == LV_HIGH || level_nxt == LV_OUT) ? high_out_r
                                                                   : low_out_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_value  = out_value_r;
  assign out_ch.state_code = out_code_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compare_mode_r <= 1'b0;
      emit_mode_r    <= EM_CHANGE;
      interval_r     <= '0;
      lower_r        <= '0;
      upper_r        <= '0;
      band_r         <= '0;
      low_out_r      <= '0;
      high_out_r     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_COMPARE_MODE: compare_mode_r <= cfg_data[0];
        REG_EMIT_MODE:    emit_mode_r    <= emit_t'(cfg_data[1:0]);
        REG_INTERVAL:     interval_r     <= cfg_data[IVL_W-1:0];
        REG_LOWER_LIMIT:  lower_r        <= cfg_data;
        REG_UPPER_LIMIT:  upper_r        <= cfg_data;
        REG_HYST_BAND:    band_r         <= cfg_data[BAND_W-1:0];
        REG_LOW_OUTPUT:   low_out_r      <= cfg_data;
        REG_HIGH_OUTPUT:  high_out_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // checks
  `HWC_ASSERT_NEXT(a_valid_sample_starts_run, accept && in_ch.sample_valid, state_r == ST_RUN)
  `HWC_ASSERT_NEXT(a_invalid_sample_dropped, accept && !in_ch.sample_valid, state_r == ST_IDLE && !$rose(out_valid_r))
  `HWC_ASSERT_IMPL(a_result_has_level, out_valid_r, out_code_r != LV_NONE)
  `HWC_ASSERT_IMPL(a_result_after_eval, $rose(out_valid_r), $past(state_r) == ST_EVAL)

endmodule

// ----- design/hwc_serial_cmp.sv -----
// ---------------------------------------------------------------------------
// hwc_serial_cmp
// Bit-serial comparator: forms four sign-extended differences LSB first and
// keeps the sign of each as the comparison flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hwc_serial_cmp (
  input  logic                              clk,
  input  hwc_pkg::step_ctrl_t               ctrl,
  input  logic signed [hwc_pkg::DATA_W-1:0] sample,
  input  logic signed [hwc_pkg::DATA_W-1:0] lower,
  input  logic signed [hwc_pkg::DATA_W-1:0] upper,
  input  logic        [hwc_pkg::BAND_W-1:0] band,
  output hwc_pkg::cmp_flags_t               flags
);
  import hwc_pkg::*;

  logic [DATA_W-1:0] s_r, lo_r, hi_r, band_r;
  // carries: A = s - hi - band, B = lo - band - s, C = s - lo, D = hi - s
  logic ca1_r, ca2_r, cb1_r, cb2_r, cc_r, cd_r;
  logic ca1_nxt, ca2_nxt, cb1_nxt, cb2_nxt, cc_nxt, cd_nxt;
  logic a1, a2, b1, b2, c1, d1;
  logic sa_r, sb_r, sc_r, sd_r;

  always_comb begin
    {ca1_nxt, a1} = fa(s_r[0], ~hi_r[0], ca1_r);
    {ca2_nxt, a2} = fa(a1, ~band_r[0], ca2_r);
    {cb1_nxt, b1} = fa(lo_r[0], ~band_r[0], cb1_r);
    {cb2_nxt, b2} = fa(b1, ~s_r[0], cb2_r);
    {cc_nxt, c1}  = fa(s_r[0], ~lo_r[0], cc_r);
    {cd_nxt, d1}  = fa(hi_r[0], ~s_r[0], cd_r);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      s_r    <= sample;
      lo_r   <= lower;
      hi_r   <= upper;
      band_r <= {1'b0, band};
      // subtraction as add of the complement plus one
      ca1_r  <= 1'b1;
      ca2_r  <= 1'b1;
      cb1_r  <= 1'b1;
      cb2_r  <= 1'b1;
      cc_r   <= 1'b1;
      cd_r   <= 1'b1;
    end else if (ctrl.cmp_step) begin
      // arithmetic shift: the MSB repeats as sign extension
      s_r    <= {s_r[DATA_W-1], s_r[DATA_W-1:1]};
      lo_r   <= {lo_r[DATA_W-1], lo_r[DATA_W-1:1]};
      hi_r   <= {hi_r[DATA_W-1], hi_r[DATA_W-1:1]};
      band_r <= {band_r[DATA_W-1], band_r[DATA_W-1:1]};
      ca1_r  <= ca1_nxt;
      ca2_r  <= ca2_nxt;
      cb1_r  <= cb1_nxt;
      cb2_r  <= cb2_nxt;
      cc_r   <= cc_nxt;
      cd_r   <= cd_nxt;
      // the last step leaves the sign bit of each difference
      sa_r   <= a2;
      sb_r   <= b2;
      sc_r   <= c1;
      sd_r   <= d1;
    end
  end

  assign flags.ge_hi = ~sa_r;
  assign flags.le_lo = ~sb_r;
  assign flags.lt_lo = sc_r;
  assign flags.gt_hi = sd_r;

endmodule

// ----- design/hwc_serial_mod.sv -----
// ---------------------------------------------------------------------------
// hwc_serial_mod
// Restoring divider, one dividend bit per cycle; reports a zero remainder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hwc_serial_mod (
  input  logic                       clk,
  input  hwc_pkg::step_ctrl_t        ctrl,
  input  logic [hwc_pkg::DATA_W-1:0] dividend,
  input  logic [hwc_pkg::IVL_W-1:0]  divisor,
  output logic                       rem_zero
);
  import hwc_pkg::*;

  logic [DATA_W-1:0] q_r;
  logic [IVL_W-1:0]  div_r;
  logic [IVL_W-1:0]  rem_r, rem_nxt;
  logic [IVL_W:0]    trial;
  logic [IVL_W:0]    diff;

  always_comb begin
    trial = {rem_r, q_r[DATA_W-1]};
    diff  = trial - {1'b0, div_r};
    // remainder stays below the divisor, so it fits IVL_W bits
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = diff[IVL_W-1:0];
    end else begin
      rem_nxt = trial[IVL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q_r   <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (ctrl.div_step) begin
      q_r   <= {q_r[DATA_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rem_zero = (rem_r == '0);

endmodule

// ----- sim/tb_hysteresis_window_comparator.sv -----
// ---------------------------------------------------------------------------
// tb_hysteresis_window_comparator
// Self-checking bench for the hysteresis window comparator. A clocked driver
// feeds samples from a pending queue in random bursts, and a clocked monitor
// takes results under a random stall pattern. Each accepted sample runs
// through a local level predictor, and every result is checked field by field.
// Directed settings cover the threshold extremes, the unset level, the
// boundary and interval modes and a level held over a mode change. Random
// settings follow them, half of their samples landing near a limit or threshold.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hysteresis_window_comparator;
  import hwc_pkg::*;

  localparam int ITEMS_PER_PHASE = 250;
  localparam int RAND_PHASES     = 8;
  localparam int DRAIN_CYCLES    = 48;

  typedef struct {
    logic signed [31:0] sample;
    logic               sample_valid;
    logic        [31:0] time_sec;
    bit                 wait_drain;   // hold off until all results are in
  } sample_item_t;

  typedef struct {
    logic signed [31:0] value;
    level_t             level;
  } level_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data  = '0;

  hwc_in_if  in_ch ();
  hwc_out_if out_ch ();

  hysteresis_window_comparator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // local copy of the settings and the level
  logic               cmp_window   = 1'b0;
  logic [1:0]         emit_sel     = 2'd0;
  logic [15:0]        interval_len = '0;
  logic signed [31:0] lower_lim    = '0;
  logic signed [31:0] upper_lim    = '0;
  logic [30:0]        band_width   = '0;
  logic signed [31:0] low_val      = '0;
  logic signed [31:0] high_val     = '0;
  level_t             model_level  = INITIAL_STATE_DEF;

  sample_item_t  pending_samples[$];
  level_result_t expected_outputs[$];

  int queued_total   = 0;
  int accepted_total = 0;
  int valid_sent     = 0;
  int ignored_sent   = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int settings_used  = 0;

  // Update the level for one sample; returns 1 when a result is due.
  function automatic bit update_level(input sample_item_t it, output level_result_t res);
    logic signed [33:0] s34, lo34, hi34, band34;
    level_t             nxt;
    bit                 fire, changed;
    res.value = '0;
    res.level = LV_NONE;
    if (!it.sample_valid) return 0;
    s34    = it.sample;
    lo34   = lower_lim;
    hi34   = upper_lim;
    band34 = {3'b000, band_width};
    nxt    = model_level;
    if (!cmp_window) begin
      // thresholds formed at full width, so no wrap; low wins a tie
      if (s34 >= hi34 + band34) nxt = LV_HIGH;
      if (s34 <= lo34 - band34) nxt = LV_LOW;
    end else begin
      nxt = (s34 < lo34 || s34 > hi34) ? LV_OUT : LV_IN;
    end
    fire = (emit_sel == EM_ALWAYS) ||
           ((emit_sel == EM_INTERVAL) && (interval_len != 0) &&
            ((it.time_sec % interval_len) == 0));
    changed     = (nxt != model_level);
    model_level = nxt;
    if (!(changed || fire)) return 0;
    case (model_level)
      LV_HIGH, LV_OUT: res.value = high_val;
      LV_LOW, LV_IN:   res.value = low_val;
      default:         return 0;
    endcase
    res.level = model_level;
    return 1;
  endfunction

  function automatic void flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
  endfunction

  // Driver: bursts of transactions with random gaps between them
  sample_item_t on_bus;
  int           gap_left   = 0;
  int           burst_left = 1;

  always @(posedge clk) begin
    level_result_t res;
    if (!rst_n) begin
      in_ch.valid        <= 1'b0;
      in_ch.sample       <= '0;
      in_ch.sample_valid <= 1'b0;
      in_ch.time_sec     <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (update_level(on_bus, res)) expected_outputs.push_back(res);
        if (on_bus.sample_valid) valid_sent++;
        else ignored_sent++;
        accepted_total++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_samples.size() != 0 &&
                     !(pending_samples[0].wait_drain && expected_outputs.size() != 0)) begin
          on_bus = pending_samples.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.sample       <= on_bus.sample;
          in_ch.sample_valid <= on_bus.sample_valid;
          in_ch.time_sec     <= on_bus.time_sec;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              1, 2:    gap_left = $urandom_range(1, 6);
              default: gap_left = $urandom_range(7, 45);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall pattern of alternating stall and run stretches
  bit rx_stall = 1'b0;
  int rx_left  = 0;

  always @(posedge clk) begin
    level_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_outputs.size() == 0) begin
          flag_mismatch("unexpected result, out_value", 'x, out_ch.out_value);
        end else begin
          want = expected_outputs.pop_front();
          if (out_ch.out_value !== want.value)
            flag_mismatch("out_value", want.value, out_ch.out_value);
          if (out_ch.state_code !== want.level)
            flag_mismatch("state_code", want.level, out_ch.state_code);
        end
      end
      if (rx_left == 0) begin
        rx_stall = !rx_stall;
        if (rx_stall) rx_left = $urandom_range(1, 12);
        else if ($urandom_range(0, 7) == 0) rx_left = 300;
        else rx_left = $urandom_range(1, 20);
      end else begin
        rx_left--;
      end
      out_ch.ready <= !rx_stall;
    end
  end

  // Write all eight registers; unused upper data bits carry junk.
  task automatic set_config(input logic cm, input logic [1:0] em, input logic [15:0] ivl,
                            input logic [31:0] lo, input logic [31:0] hi,
                            input logic [30:0] band, input logic [31:0] lowv,
                            input logic [31:0] highv);
    logic [31:0] word [8];
    logic [31:0] junk;
    junk = $urandom();
    word[REG_COMPARE_MODE] = {junk[31:1], cm};
    junk = $urandom();
    word[REG_EMIT_MODE]    = {junk[31:2], em};
    junk = $urandom();
    word[REG_INTERVAL]     = {junk[31:16], ivl};
    word[REG_LOWER_LIMIT]  = lo;
    word[REG_UPPER_LIMIT]  = hi;
    junk = $urandom();
    word[REG_HYST_BAND]    = {junk[31], band};
    word[REG_LOW_OUTPUT]   = lowv;
    word[REG_HIGH_OUTPUT]  = highv;
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= word[i];
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    for (int i = 0; i < 8; i++) begin
      case (cfg_reg_t'(i))
        REG_COMPARE_MODE: cmp_window   = word[i][0];
        REG_EMIT_MODE:    emit_sel     = word[i][1:0];
        REG_INTERVAL:     interval_len = word[i][15:0];
        REG_LOWER_LIMIT:  lower_lim    = word[i];
        REG_UPPER_LIMIT:  upper_lim    = word[i];
        REG_HYST_BAND:    band_width   = word[i][30:0];
        REG_LOW_OUTPUT:   low_val      = word[i];
        REG_HIGH_OUTPUT:  high_val     = word[i];
        default: ;
      endcase
    end
    settings_used++;
  endtask

  task automatic push_sample(input logic [31:0] s, input logic v, input logic [31:0] t,
                             input bit hold);
    sample_item_t it;
    it.sample       = s;
    it.sample_valid = v;
    it.time_sec     = t;
    it.wait_drain   = hold;
    pending_samples.push_back(it);
    queued_total++;
  endtask

  // Wait for every queued sample and result, then let the pipeline empty.
  task automatic wait_quiet();
    do @(posedge clk);
    while (accepted_total != queued_total || expected_outputs.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic               r_cm;
    logic [1:0]         r_em;
    logic [15:0]        r_ivl;
    logic signed [31:0] r_lo, r_hi, r_s;
    logic [30:0]        r_band;
    logic [31:0]        r_t;
    logic signed [33:0] anchor;
    logic               r_v;
    int                 valid_n;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Unset level held in always mode, then both thresholds at their edges
    set_config(1'b0, EM_ALWAYS, 16'd0, 32'hFF9C_0000, 32'h0064_0000, 31'h0001_0000,
               32'h8000_0000, 32'h7FFF_FFFF);
    push_sample(32'h0000_0000, 1'b1, 32'd0, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0);
    push_sample(32'h0065_0000, 1'b1, 32'd1, 1'b0);
    push_sample(32'h0064_FFFF, 1'b1, 32'd2, 1'b0);
    push_sample(32'hFF9B_0000, 1'b1, 32'd3, 1'b0);
    push_sample(32'hFF9B_0001, 1'b1, 32'd4, 1'b0);
    push_sample(32'h8000_0000, 1'b1, 32'd5, 1'b0);
    wait_quiet();

    // Widest limits and band: the thresholds lie beyond the sample range
    set_config(1'b0, EM_CHANGE, 16'd1, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
               32'h0000_0000, 32'hFFFF_FFFF);
    push_sample(32'h7FFF_FFFF, 1'b1, 32'd0, 1'b0);
    push_sample(32'h8000_0000, 1'b1, 32'd0, 1'b0);
    push_sample(32'h0000_0000, 1'b1, 32'd0, 1'b0);
    wait_quiet();

    // Equal limits, zero band: both tests hold and low wins; unused emit code
    set_config(1'b0, 2'd3, 16'd7, 32'h0005_0000, 32'h0005_0000, 31'd0,
               32'd1, 32'd2);
    push_sample(32'h0005_0000, 1'b1, 32'd0, 1'b0);
    push_sample(32'h0005_0001, 1'b1, 32'd7, 1'b0);
    push_sample(32'h0005_0000, 1'b1, 32'd14, 1'b0);
    push_sample(32'h0004_0000, 1'b1, 32'd21, 1'b0);
    wait_quiet();

    // Boundary mode, interval mode with a zero interval
    set_config(1'b1, EM_INTERVAL, 16'd0, 32'hFFFF_FFFF, 32'h0000_0001, 31'h7FFF_FFFF,
               32'h1234_5678, 32'hEDCB_A987);
    push_sample(32'hFFFF_FFFE, 1'b1, 32'd0, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0);
    push_sample(32'h0000_0001, 1'b1, 32'd0, 1'b1);
    push_sample(32'h0000_0002, 1'b1, 32'd0, 1'b0);
    wait_quiet();

    // Largest interval: the top timestamp is a multiple of it
    set_config(1'b1, EM_INTERVAL, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0001, 31'd0,
               32'h1234_5678, 32'hEDCB_A987);
    push_sample(32'h0000_0000, 1'b1, 32'd65534, 1'b0);
    push_sample(32'h0000_0000, 1'b1, 32'd0, 1'b0);
    push_sample(32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1);
    push_sample(32'h0000_0000, 1'b1, 32'd196605, 1'b0);
    push_sample(32'h0000_0005, 1'b1, 32'd65534, 1'b0);
    wait_quiet();

    // Back to threshold mode: the outside level holds in the dead band
    set_config(1'b0, EM_ALWAYS, 16'd3, 32'hFC18_0000, 32'h03E8_0000, 31'd10,
               32'h0BAD_0000, 32'h0600_D000);
    push_sample(32'h0000_0000, 1'b1, 32'd9, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b1, 32'd10, 1'b0);
    wait_quiet();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      r_cm = $urandom_range(0, 1);
      r_em = $urandom_range(0, 3);
      case ($urandom_range(0, 4))
        0:       r_ivl = 16'd0;
        1:       r_ivl = 16'hFFFF;
        2:       r_ivl = 16'd1;
        3:       r_ivl = $urandom_range(2, 12);
        default: r_ivl = $urandom();
      endcase
      if ($urandom_range(0, 3) == 0) r_lo = $urandom();
      else r_lo = $signed($urandom()) >>> $urandom_range(4, 12);
      if ($urandom_range(0, 3) == 0) r_hi = $urandom();
      else r_hi = r_lo + $urandom_range(0, 32'h0040_0000);
      case ($urandom_range(0, 3))
        0:       r_band = 31'd0;
        1:       r_band = 31'h7FFF_FFFF;
        2:       r_band = $urandom_range(0, 32'h0002_0000);
        default: r_band = $urandom();
      endcase
      set_config(r_cm, r_em, r_ivl, r_lo, r_hi, r_band, $urandom(), $urandom());

      valid_n = 0;
      while (valid_n < ITEMS_PER_PHASE) begin
        r_v = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 7))
          0, 1, 2, 3: begin
            // land on or next to a limit or a threshold
            case ($urandom_range(0, 3))
              0:       anchor = r_lo;
              1:       anchor = r_hi;
              2:       anchor = r_lo - $signed({3'b000, r_band});
              default: anchor = r_hi + $signed({3'b000, r_band});
            endcase
            anchor = anchor + ($signed($urandom_range(0, 8)) - 4);
            if (anchor > 34'sd2147483647) r_s = 32'h7FFF_FFFF;
            else if (anchor < -34'sd2147483648) r_s = 32'h8000_0000;
            else r_s = anchor[31:0];
          end
          4: begin
            case ($urandom_range(0, 3))
              0:       r_s = 32'h8000_0000;
              1:       r_s = 32'h7FFF_FFFF;
              2:       r_s = 32'h0000_0000;
              default: r_s = 32'hFFFF_FFFF;
            endcase
          end
          default: r_s = $urandom();
        endcase
        if (r_ivl != 0 && $urandom_range(0, 1) == 0)
          r_t = r_ivl * $urandom_range(0, 65535) + ($urandom_range(0, 3) == 0);
        else
          r_t = $urandom();
        push_sample(r_s, r_v, r_t, $urandom_range(0, 63) == 0);
        if (r_v) valid_n++;
      end
      wait_quiet();
    end

    $display("Checked %0d results from %0d valid and %0d ignored samples", results_seen,
             valid_sent, ignored_sent);
    $display("over %0d register settings, %0d mismatches", settings_used, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Timed out with %0d results outstanding", expected_outputs.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
